@@ sv/rgb_point_filter_top_defines.svh @@
// ----------------------------------------------------------------------------
// rgb_point_filter_top_defines.svh
// Assertion macros shared by the point filter RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_POINT_FILTER_TOP_DEFINES_SVH
`define RGB_POINT_FILTER_TOP_DEFINES_SVH

// A property that must hold at every rising clock edge outside reset.
`define RPF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication checked at every rising clock edge outside reset.
`define RPF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ sv/rpf_pkg.sv @@
// ----------------------------------------------------------------------------
// rpf_pkg
// Types, codes and constants of the RGB point filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpf_pkg;

	localparam int unsigned CHANNEL_MAX = 255;

	// One pixel in, one pixel out.
	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} pix_out_t;

	typedef enum logic [3:0] {
		MODE_RED     = 4'd0,
		MODE_GREEN   = 4'd1,
		MODE_BLUE    = 4'd2,
		MODE_GRAY    = 4'd3,
		MODE_SEPIA   = 4'd4,
		MODE_TURQ    = 4'd5,
		MODE_INVERT  = 4'd6,
		MODE_NOISE   = 4'd7,
		MODE_BRIGHT  = 4'd8,
		MODE_DARK    = 4'd9,
		MODE_THRESH  = 4'd10
	} filter_mode_t;

	// Register indexes of the write port.
	localparam logic [1:0] CFG_FILTER_MODE = 2'd0;
	localparam logic [1:0] CFG_BRIGHT_OFF  = 2'd1;
	localparam logic [1:0] CFG_NOISE_AMP   = 2'd2;
	localparam logic [1:0] CFG_BW_THRESH   = 2'd3;

	localparam logic [3:0] RST_FILTER_MODE = 4'd0;
	localparam logic [7:0] RST_BRIGHT_OFF  = 8'd65;
	localparam logic [6:0] RST_NOISE_AMP   = 7'd25;
	localparam logic [7:0] RST_BW_THRESH   = 8'd113;

	localparam logic [31:0] LFSR_SEED = 32'hACE1_ACE1;
	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

	// Q0.16 weights. Sepia rows are the red, green and blue output sums.
	localparam logic [15:0] GRAY_K [3] = '{16'd19595, 16'd38470, 16'd7471};
	localparam logic [15:0] SEP_K [3][3] = '{
		'{16'd25756, 16'd50397, 16'd12386},
		'{16'd22872, 16'd44958, 16'd11010},
		'{16'd17826, 16'd34996, 16'd8585}
	};

	// Reciprocal sequencer: steps 0..SEQ_LAST compute floor(2^24 / span)
	// and, on the way, 2^8, 2^16 and 2^24 modulo span.
	localparam int unsigned RECIP_SHIFT = 24;
	localparam logic [4:0]  SEQ_POW8    = 5'd8;
	localparam logic [4:0]  SEQ_POW16   = 5'd16;
	localparam logic [4:0]  SEQ_LAST    = 5'd24;

	function automatic logic [31:0] lfsr_step(input logic [31:0] v);
		logic [31:0] n;
		n = {1'b0, v[31:1]};
		if (v[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

endpackage

@@ sv/rgb_point_filter_top.sv @@
// An accepted pixel passes stage registers 1 to 4 and the output register to reach out_word.
// One pixel per clock while out_stall is low and busy_q is clear; the five-register pipeline
// advances stage by stage under stall. Noise uses a reciprocal sequencer that runs after
// reset and after every noise_amplitude write; in_stall stays high while it runs.
// Reset (arst_n low, asynchronous) empties the pipeline and loads register defaults and LFSR seed.
// ----------------------------------------------------------------------------
// rgb_point_filter_top
// Per-pixel color filter: channel select, gray, sepia, turquoise, invert, noise,
// brightness and black/white threshold on a valid/stall pixel stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_point_filter_top_defines.svh"

module rgb_point_filter_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  rpf_pkg::pix_in_t in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output rpf_pkg::pix_out_t out_word,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data
);
	import rpf_pkg::*;

	// Configuration registers.
	logic [3:0] filter_mode_q;
	logic [7:0] bright_offset_q;
	logic [6:0] noise_amp_q;
	logic [7:0] bw_thresh_q;
	logic [31:0] lfsr_q;

	// Reciprocal sequencer. The noise span 2A+1 is fixed between writes, so
	// the modulo runs as a multiply by a precomputed reciprocal.
	logic        busy_q;
	logic [4:0]  seq_cnt_q;
	logic [7:0]  seq_rem_q;
	logic [24:0] seq_quo_q;
	logic [7:0]  t8_q, t16_q, t24_q;
	logic [24:0] recip_q;
	logic [7:0]  span;
	logic [8:0]  rem_dbl;
	logic [7:0]  rem_next;
	logic        quo_bit;

	assign span = {noise_amp_q, 1'b1};

	always_comb begin
		rem_dbl = {seq_rem_q, (seq_cnt_q == 5'd0)};
		quo_bit = (rem_dbl >= {1'b0, span});
		rem_next = quo_bit ? 8'(rem_dbl - {1'b0, span}) : rem_dbl[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= RST_FILTER_MODE;
			bright_offset_q <= RST_BRIGHT_OFF;
			noise_amp_q <= RST_NOISE_AMP;
			bw_thresh_q <= RST_BW_THRESH;
			busy_q <= 1'b1;
			seq_cnt_q <= 5'd0;
			seq_rem_q <= 8'd0;
			seq_quo_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FILTER_MODE: filter_mode_q <= cfg_data[3:0];
				CFG_BRIGHT_OFF:  bright_offset_q <= cfg_data;
				CFG_NOISE_AMP: begin
					noise_amp_q <= cfg_data[6:0];
					busy_q <= 1'b1;
					seq_cnt_q <= 5'd0;
					seq_rem_q <= 8'd0;
					seq_quo_q <= '0;
				end
				CFG_BW_THRESH:   bw_thresh_q <= cfg_data;
				default: ;
			endcase
		end else if (busy_q) begin
			seq_rem_q <= rem_next;
			seq_quo_q <= {seq_quo_q[23:0], quo_bit};
			seq_cnt_q <= seq_cnt_q + 5'd1;
			if (seq_cnt_q == SEQ_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Results of the sequencer; no reset needed, they are rebuilt before use.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (seq_cnt_q == SEQ_POW8) begin
				t8_q <= rem_next;
			end
			if (seq_cnt_q == SEQ_POW16) begin
				t16_q <= rem_next;
			end
			if (seq_cnt_q == SEQ_LAST) begin
				t24_q <= rem_next;
				recip_q <= {seq_quo_q[23:0], quo_bit};
			end
		end
	end

	// Pipeline handshake: each stage moves when the next one is empty or moving.
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4, en_out;
	logic accept;

	assign en_out = !out_valid || !out_stall;
	assign en_s4 = !v_s4 || en_out;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_stall = !en_s1 || busy_q;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
			lfsr_q <= LFSR_SEED;
		end else begin
			if (en_s1) begin
				v_s1 <= accept;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_out) begin
				out_valid <= v_s4;
			end
			// The LFSR steps once per channel, and only when noise is applied.
			if (accept && filter_mode_q == MODE_NOISE) begin
				lfsr_q <= lfsr_step(lfsr_step(lfsr_step(lfsr_q)));
			end
		end
	end

	// Stage 1: input register with the three LFSR draws of this pixel.
	logic [7:0]  px_s1 [3];
	logic [31:0] rnd_s1 [3];
	logic [31:0] rnd1, rnd2, rnd3;

	assign rnd1 = lfsr_step(lfsr_q);
	assign rnd2 = lfsr_step(rnd1);
	assign rnd3 = lfsr_step(rnd2);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			px_s1[0] <= in_word.red_in;
			px_s1[1] <= in_word.green_in;
			px_s1[2] <= in_word.blue_in;
			rnd_s1[0] <= rnd1;
			rnd_s1[1] <= rnd2;
			rnd_s1[2] <= rnd3;
		end
	end

	// Stage 2: every filter except noise, plus the byte-wise reduction of
	// each draw to an 18-bit value with the same remainder modulo the span.
	logic [7:0]  res_c [3];
	logic [17:0] fold_c [3];
	logic [7:0]  res_s2 [3];
	logic [17:0] fold_s2 [3];
	logic [7:0]  px_s2 [3];

	always_comb begin
		logic [23:0] gprod [3];
		logic [9:0]  gsum;
		logic [7:0]  gray;
		logic [25:0] macc;
		logic [7:0]  mix [3];
		logic [9:0]  bsum [3];
		logic [9:0]  csum;
		logic [10:0] lim;
		logic        white;
		for (int k = 0; k < 3; k++) begin
			gprod[k] = 24'(px_s1[k]) * 24'(GRAY_K[k]);
			macc = 26'(px_s1[0]) * 26'(SEP_K[k][0]) + 26'(px_s1[1]) * 26'(SEP_K[k][1])
				+ 26'(px_s1[2]) * 26'(SEP_K[k][2]);
			mix[k] = (macc[25:16] > 10'(CHANNEL_MAX)) ? 8'(CHANNEL_MAX) : macc[23:16];
			bsum[k] = 10'(px_s1[k]) + 10'(bright_offset_q);
			fold_c[k] = 18'(rnd_s1[k][7:0]) + 18'(rnd_s1[k][15:8]) * 18'(t8_q)
				+ 18'(rnd_s1[k][23:16]) * 18'(t16_q) + 18'(rnd_s1[k][31:24]) * 18'(t24_q);
		end
		gsum = 10'(gprod[0][23:16]) + 10'(gprod[1][23:16]) + 10'(gprod[2][23:16]);
		gray = (gsum > 10'(CHANNEL_MAX)) ? 8'(CHANNEL_MAX) : gsum[7:0];
		// (r+g+b)/3 > t is the same as r+g+b >= 3t+3.
		csum = 10'(px_s1[0]) + 10'(px_s1[1]) + 10'(px_s1[2]);
		lim = 11'(bw_thresh_q) * 11'd3 + 11'd3;
		white = ({1'b0, csum} >= lim);
		for (int k = 0; k < 3; k++) begin
			res_c[k] = px_s1[k];
		end
		case (filter_mode_q)
			MODE_RED: begin
				res_c[1] = 8'd0;
				res_c[2] = 8'd0;
			end
			MODE_GREEN: begin
				res_c[0] = 8'd0;
				res_c[2] = 8'd0;
			end
			MODE_BLUE: begin
				res_c[0] = 8'd0;
				res_c[1] = 8'd0;
			end
			MODE_GRAY: begin
				for (int k = 0; k < 3; k++) res_c[k] = gray;
			end
			MODE_SEPIA: begin
				for (int k = 0; k < 3; k++) res_c[k] = mix[k];
			end
			MODE_TURQ: begin
				res_c[0] = mix[2];
				res_c[1] = mix[0];
				res_c[2] = mix[1];
			end
			MODE_INVERT: begin
				for (int k = 0; k < 3; k++) res_c[k] = 8'(CHANNEL_MAX) - px_s1[k];
			end
			MODE_BRIGHT: begin
				for (int k = 0; k < 3; k++) begin
					res_c[k] = (bsum[k] > 10'(CHANNEL_MAX)) ? 8'(CHANNEL_MAX) : bsum[k][7:0];
				end
			end
			MODE_DARK: begin
				for (int k = 0; k < 3; k++) begin
					res_c[k] = (px_s1[k] < bright_offset_q) ? 8'd0 : px_s1[k] - bright_offset_q;
				end
			end
			MODE_THRESH: begin
				for (int k = 0; k < 3; k++) res_c[k] = white ? 8'(CHANNEL_MAX) : 8'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int k = 0; k < 3; k++) begin
				res_s2[k] <= res_c[k];
				fold_s2[k] <= fold_c[k];
				px_s2[k] <= px_s1[k];
			end
		end
	end

	// Stage 3: quotient estimate, low by at most one.
	logic [42:0] qprod [3];
	logic [17:0] quo_s3 [3];
	logic [17:0] fold_s3 [3];
	logic [7:0]  res_s3 [3];
	logic [7:0]  px_s3 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qprod[k] = 43'(fold_s2[k]) * 43'(recip_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int k = 0; k < 3; k++) begin
				quo_s3[k] <= qprod[k][RECIP_SHIFT +: 18];
				fold_s3[k] <= fold_s2[k];
				res_s3[k] <= res_s2[k];
				px_s3[k] <= px_s2[k];
			end
		end
	end

	// Stage 4: remainder with one correction step.
	logic [7:0] rem_c [3];
	logic [7:0] rem_s4 [3];
	logic [7:0] res_s4 [3];
	logic [7:0] px_s4 [3];

	always_comb begin
		logic [25:0] back;
		logic [17:0] diff;
		for (int k = 0; k < 3; k++) begin
			back = 26'(quo_s3[k]) * 26'(span);
			diff = fold_s3[k] - back[17:0];
			rem_c[k] = (diff[8:0] >= {1'b0, span}) ? 8'(diff[8:0] - {1'b0, span}) : diff[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int k = 0; k < 3; k++) begin
				rem_s4[k] <= rem_c[k];
				res_s4[k] <= res_s3[k];
				px_s4[k] <= px_s3[k];
			end
		end
	end

	// Output register: noise is channel + remainder - amplitude, clamped.
	logic [7:0] fin_c [3];

	always_comb begin
		logic signed [10:0] nsum;
		for (int k = 0; k < 3; k++) begin
			nsum = $signed({3'b000, px_s4[k]}) + $signed({3'b000, rem_s4[k]})
				- $signed({4'b0000, noise_amp_q});
			if (filter_mode_q != MODE_NOISE) begin
				fin_c[k] = res_s4[k];
			end else if (nsum < 0) begin
				fin_c[k] = 8'd0;
			end else if (nsum > 11'sd255) begin
				fin_c[k] = 8'(CHANNEL_MAX);
			end else begin
				fin_c[k] = nsum[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_word.red_out <= fin_c[0];
			out_word.green_out <= fin_c[1];
			out_word.blue_out <= fin_c[2];
		end
	end

	// The Galois LFSR is invertible, so it can never reach the all-zero state.
	`RPF_ASSERT(a_lfsr_nonzero, lfsr_q != 32'd0, "noise LFSR reached zero")
	// No pixel may enter while the reciprocal is being rebuilt.
	`RPF_ASSERT_IMPL(a_busy_blocks, busy_q, in_stall, "pixel accepted during sequencer run")
	// The sequencer stops at its last step.
	`RPF_ASSERT_IMPL(a_seq_bound, busy_q, seq_cnt_q <= SEQ_LAST, "sequencer ran past last step")
	// A full output stage held by the sink keeps stage 4 from moving.
	`RPF_ASSERT_IMPL(a_hold, out_valid && out_stall && v_s4, !en_s4, "stage 4 moved under stall")

endmodule
